FILE: rtl/lpp_pkg.sv
// Shared constants and codes for the LRU pool with pinned entries.
`default_nettype none

package lpp_pkg;

  // Payload widths fixed by the item formats
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Defaults
  localparam int POOL_ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

  // Register indexes
  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ACCESS  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PIN     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNPIN   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALL_PINNED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT     = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/lpp_req_if.sv
// Command channel: valid/ready with command and key.
`default_nettype none

interface lpp_req_if
  import lpp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink   (input valid, command, key, output ready);
endinterface

`default_nettype wire

FILE: rtl/lpp_res_if.sv
// Result channel: valid/ready with the outcome of one command.
`default_nettype none

interface lpp_res_if
  import lpp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [SLOT_W-1:0]   slot;
  logic                evicted;
  logic [KEY_W-1:0]    evicted_key;
  logic [STATUS_W-1:0] status;

  modport source (output valid, hit, slot, evicted, evicted_key, status, input ready);
  modport sink   (input valid, hit, slot, evicted, evicted_key, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/lpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word; the read data is registered from the read address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lru_pool_with_pinning.sv
// LRU pool with pinned entries: top level, sequencer and recency list.
//
// Usage: one command item (access, pin, unpin, release, clear) enters on req
// and yields exactly one result item on rsp. The capacity register sits at
// APB byte address 0 and must be written only while the block is idle; the
// block itself does not enforce this. Keys live in a RAM; the block walks it
// one slot a cycle through a single key comparator, then walks the recency
// list one position a cycle. Clear or an unknown command goes straight to
// the result load. Other commands run the slot scan, then as needed either
// the recency-position search or an insert, preceded by the eviction walk
// and evicted-key read when the pool is full, and last the result load.
// Throughput: one item at a time; req.ready is high only in the idle state.
// A finished result waits in the output register while the next item is
// accepted; when rsp stalls, the sequencer holds its next result back until
// the output register frees.
// Reset (rst, synchronous): pool empty, all pin marks clear, capacity 16,
// no result pending. There is no clearing pass.
`default_nettype none

module lru_pool_with_pinning
  import lpp_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lpp_req_if.sink                    req,
  lpp_res_if.source                  rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int CW    = CNT_W + CAP_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_POS    = 7'b0000100,
    ST_EVICT  = 7'b0001000,
    ST_EVRD   = 7'b0010000,
    ST_INSERT = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;

  // Configuration
  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    count_ext;
  logic             cfg_wr;

  // Pool state
  logic [POOL_ENTRIES-1:0] slot_valid;
  logic [POOL_ENTRIES-1:0] slot_pinned;
  logic [IDX_W-1:0]        order [POOL_ENTRIES];
  logic [CNT_W-1:0]        count;

  // Item in flight
  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] hit_slot;
  logic             free_found;
  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] ev_slot;
  logic [CNT_W-1:0] rot_cnt;

  // Working result
  logic                w_hit;
  logic [IDX_W-1:0]    w_slot;
  logic                w_ev;
  logic [KEY_W-1:0]    w_evk;
  logic [STATUS_W-1:0] w_status;

  // Output register
  logic                rsp_valid;
  logic                o_hit;
  logic [IDX_W-1:0]    o_slot;
  logic                o_ev;
  logic [KEY_W-1:0]    o_evk;
  logic [STATUS_W-1:0] o_status;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  // Key RAM
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // Shared comparator and list helpers
  logic             key_match;
  logic [IDX_W-1:0] idx_lo;
  logic [IDX_W-1:0] head_slot;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] tail_idx;
  logic             pos_match;
  logic             accept;

  assign accept    = req.valid && req.ready;
  assign idx_lo    = idx[IDX_W-1:0];
  assign key_match = slot_valid[idx_lo] && (ram_rdata == key_r);
  assign head_slot = order[0];
  assign cnt_m1    = count - 1'b1;
  assign tail_idx  = cnt_m1[IDX_W-1:0];
  assign pos_match = (order[idx_lo] == hit_slot) || (idx + 1'b1 >= count);

  // Clamp capacity into 1..POOL_ENTRIES
  assign cap_ext   = {{CNT_W{1'b0}}, capacity};
  assign count_ext = {{CAP_W{1'b0}}, count};
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(POOL_ENTRIES)) begin
      eff_cap = CW'(POOL_ENTRIES);
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_CAPACITY) begin
      prdata = {{(APB_DATA_W-CAP_W){1'b0}}, capacity};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Pick the key RAM read address for the next cycle
  always_comb begin
    ram_raddr = '0;
    case (state)
      ST_SCAN:  ram_raddr = idx_lo + 1'b1;
      ST_EVICT: ram_raddr = head_slot;
      default:  ram_raddr = '0;
    endcase
  end

  assign ram_we = (state == ST_INSERT) && free_found;

  lpp_ram #(
    .WIDTH (KEY_W),
    .DEPTH (POOL_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (key_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake outputs
  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.hit         = o_hit;
  assign slot_ext        = {{SLOT_W{1'b0}}, o_slot};
  assign rsp.slot        = slot_ext[SLOT_W-1:0];
  assign rsp.evicted     = o_ev;
  assign rsp.evicted_key = o_evk;
  assign rsp.status      = o_status;

  // Sequencer, pool state and recency list
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot_valid  <= '0;
      slot_pinned <= '0;
      count       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // Drop the result once taken, unless the next one loads this cycle
      if (rsp_valid && rsp.ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r      <= req.command;
            key_r      <= req.key;
            idx        <= '0;
            free_found <= 1'b0;
            rot_cnt    <= '0;
            w_hit      <= 1'b0;
            w_slot     <= '0;
            w_ev       <= 1'b0;
            w_evk      <= '0;
            w_status   <= STATUS_OK;
            if (req.command == CMD_CLEAR) begin
              slot_valid  <= '0;
              slot_pinned <= '0;
              count       <= '0;
              state       <= ST_FINISH;
            end else if (req.command > CMD_CLEAR) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        // Compare one slot per cycle; note the first free slot on the way
        ST_SCAN: begin
          if (!slot_valid[idx_lo] && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= idx_lo;
          end
          if (key_match) begin
            w_hit    <= 1'b1;
            w_slot   <= idx_lo;
            hit_slot <= idx_lo;
            if (cmd_r == CMD_PIN) begin
              slot_pinned[idx_lo] <= 1'b1;
              state               <= ST_FINISH;
            end else if (cmd_r == CMD_UNPIN) begin
              slot_pinned[idx_lo] <= 1'b0;
              state               <= ST_FINISH;
            end else begin
              idx   <= '0;
              state <= ST_POS;
            end
          end else if (idx == CNT_W'(POOL_ENTRIES - 1)) begin
            if (cmd_r != CMD_ACCESS) begin
              w_status <= STATUS_ABSENT;
              state    <= ST_FINISH;
            end else if (count_ext >= eff_cap) begin
              state <= ST_EVICT;
            end else begin
              state <= ST_INSERT;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end

        // Find the hit slot in the list, then move it to the tail or drop it
        ST_POS: begin
          if (pos_match) begin
            for (int i = 0; i < POOL_ENTRIES - 1; i++) begin
              if (CNT_W'(i) >= idx && CNT_W'(i + 1) < count) begin
                order[i] <= order[i+1];
              end
            end
            if (cmd_r == CMD_ACCESS) begin
              order[tail_idx] <= hit_slot;
            end else begin
              count                 <= cnt_m1;
              slot_valid[hit_slot]  <= 1'b0;
              slot_pinned[hit_slot] <= 1'b0;
            end
            state <= ST_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        // Rotate pinned heads to the tail; evict the first unpinned head
        ST_EVICT: begin
          if (rot_cnt == count) begin
            w_status <= STATUS_ALL_PINNED;
            state    <= ST_FINISH;
          end else begin
            for (int i = 0; i < POOL_ENTRIES - 1; i++) begin
              if (CNT_W'(i + 1) < count) begin
                order[i] <= order[i+1];
              end
            end
            if (slot_pinned[head_slot]) begin
              order[tail_idx] <= head_slot;
              rot_cnt         <= rot_cnt + 1'b1;
            end else begin
              count                 <= cnt_m1;
              slot_valid[head_slot] <= 1'b0;
              ev_slot               <= head_slot;
              w_ev                  <= 1'b1;
              state                 <= ST_EVRD;
            end
          end
        end

        // Take the evicted key; use the lower of the free slots
        ST_EVRD: begin
          w_evk      <= ram_rdata;
          free_found <= 1'b1;
          if (!free_found || ev_slot < free_slot) begin
            free_slot <= ev_slot;
          end
          state <= ST_INSERT;
        end

        // Place the new key at the most recent end
        ST_INSERT: begin
          if (free_found) begin
            slot_valid[free_slot]          <= 1'b1;
            slot_pinned[free_slot]         <= 1'b0;
            order[count[IDX_W-1:0]]        <= free_slot;
            count                          <= count + 1'b1;
            w_slot                         <= free_slot;
          end else begin
            w_status <= STATUS_ALL_PINNED;
          end
          state <= ST_FINISH;
        end

        // Load the result once the output register is free
        ST_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            o_hit     <= w_hit;
            o_slot    <= w_slot;
            o_ev      <= w_ev;
            o_evk     <= w_evk;
            o_status  <= w_status;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
